// ===== hw/rtl/vtre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtre_pkg
// Shared types, constants and decode helpers for the planar VRAM tile
// raster engine.
// ----------------------------------------------------------------------------
package vtre_pkg;

  // Default plane depth in bytes per plane
  localparam int PLANE_BYTES_DEF = 32768;

  // One memory word carries the same offset of all four planes
  localparam int PLANES = 4;
  localparam int WORD_W = 32;

  // Bus commands
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_IO    = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // I/O ports of the engine
  localparam logic [15:0] PORT_MODE = 16'h007c;
  localparam logic [15:0] PORT_TILE = 16'h007e;

  // Mode byte bits
  localparam int MODE_ON_BIT  = 7;
  localparam int MODE_RMW_BIT = 6;

  // Graphics windows
  localparam logic [19:0] WIN0_BASE = 20'ha8000;
  localparam logic [19:0] WIN1_BASE = 20'hb0000;
  localparam logic [19:0] WIN2_BASE = 20'hb8000;
  localparam logic [19:0] WIN2_END  = 20'hc0000;
  localparam logic [19:0] WIN3_BASE = 20'he0000;
  localparam logic [19:0] WIN3_END  = 20'he8000;

  // Offset within a window
  localparam logic [14:0] OFFSET_MASK = 15'h7fff;

  // Byte returned outside the windows or on an all-disabled compare
  localparam logic [7:0] FILL_BYTE = 8'hff;

  typedef struct packed {
    logic       hit;
    logic [1:0] plane;
  } win_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic finish_wr;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_is_mem;
    logic pend_read;
    logic out_busy;
  } ctrl_status_t;

  // Map a bus address to its plane window
  function automatic win_t window_decode(input logic [19:0] a);
    win_t w;
    w.hit   = 1'b1;
    w.plane = 2'd0;
    if (a >= WIN0_BASE && a < WIN1_BASE) begin
      w.plane = 2'd0;
    end else if (a >= WIN1_BASE && a < WIN2_BASE) begin
      w.plane = 2'd1;
    end else if (a >= WIN2_BASE && a < WIN2_END) begin
      w.plane = 2'd2;
    end else if (a >= WIN3_BASE && a < WIN3_END) begin
      w.plane = 2'd3;
    end else begin
      w.hit = 1'b0;
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/planar_vram_tile_raster_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_vram_tile_raster_engine_core
// Four-plane graphics memory with a tile raster engine: mode and tile port
// writes, planar or tile writes, raw reads and tile compare reads.
// ----------------------------------------------------------------------------
//  channel | signals                                   | moves
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_stall, command, bus_address, | one bus transaction
//          | write_data                                |
//  out     | out_valid, out_stall, read_data           | one memory read result
//
// A port write or an unused command is accepted and completed in the idle
// state. A memory read or write reads the plane word at accept and, in the
// finish state, writes the merged word or loads the result (one read and one
// write port on the plane memory). After reset a clear pass writes zero to
// all PLANE_BYTES words, one per cycle, with in_stall held high. A read waits
// in the finish state while an earlier result is stalled at the output.
// ----------------------------------------------------------------------------
module planar_vram_tile_raster_engine_core import vtre_pkg::*; #(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [19:0] bus_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  vtre_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  vtre_datapath #(
    .PLANE_BYTES(PLANE_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .bus_address(bus_address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// ===== hw/rtl/vtre_plane_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtre_plane_ram
// Plane memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vtre_plane_ram import vtre_pkg::*; #(
  parameter int DEPTH = PLANE_BYTES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/vtre_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtre_datapath
// Address decode, mode and tile registers, plane memory, merge and compare
// logic, clear counter and output register.
// ----------------------------------------------------------------------------
module vtre_datapath import vtre_pkg::*; #(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   command,
  input  logic [19:0]  bus_address,
  input  logic [7:0]   write_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   read_data,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t st
);

  localparam int AW = $clog2(PLANE_BYTES);
  localparam int RW = 22;

  // Reduce a window offset modulo the plane depth by conditional subtracts
  function automatic logic [AW-1:0] plane_offset(input logic [14:0] off);
    logic [RW-1:0] r;
    r = RW'(off);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (RW'(PLANE_BYTES) << k)) begin
        r = r - (RW'(PLANE_BYTES) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  logic [7:0]        mode;
  logic [7:0]        tile [PLANES];
  logic [1:0]        tile_ptr;
  logic [AW-1:0]     clr_addr;
  logic              pend_read;
  logic              hit_q;
  logic [1:0]        plane_q;
  logic [AW-1:0]     idx_q;
  logic [7:0]        data_q;
  logic [AW-1:0]     idx_in;
  win_t              win_in;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] merged;
  logic [7:0]        raw_byte;
  logic [7:0]        cmp_acc;
  logic [7:0]        result;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  assign win_in = window_decode(bus_address);
  assign idx_in = plane_offset(bus_address[14:0] & OFFSET_MASK);

  // Status toward the controller
  assign st.clr_last  = (clr_addr == AW'(PLANE_BYTES - 1));
  assign st.in_is_mem = (command == CMD_READ) || (command == CMD_WRITE);
  assign st.pend_read = pend_read;
  assign st.out_busy  = out_valid && out_stall;

  // Advance the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Handle port writes at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= '0;
      tile_ptr <= '0;
      for (int k = 0; k < PLANES; k++) begin
        tile[k] <= '0;
      end
    end else if (cmd.accept && command == CMD_IO) begin
      if (bus_address[15:0] == PORT_MODE) begin
        mode     <= write_data;
        tile_ptr <= '0;
      end else if (bus_address[15:0] == PORT_TILE) begin
        tile[tile_ptr] <= write_data;
        tile_ptr       <= tile_ptr + 2'd1;
      end
    end
  end

  // Hold the memory transaction for its finish state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_read <= (command == CMD_READ);
      hit_q     <= win_in.hit;
      plane_q   <= win_in.plane;
      idx_q     <= idx_in;
      data_q    <= write_data;
    end
  end

  // Merge the written byte or tile into the old word
  always_comb begin
    for (int k = 0; k < PLANES; k++) begin
      merged[8*k +: 8] = rdata[8*k +: 8];
      if (!mode[MODE_ON_BIT]) begin
        if (plane_q == 2'(k)) begin
          merged[8*k +: 8] = data_q;
        end
      end else if (!mode[k]) begin
        if (mode[MODE_RMW_BIT]) begin
          merged[8*k +: 8] = (rdata[8*k +: 8] & ~data_q) | (tile[k] & data_q);
        end else begin
          merged[8*k +: 8] = tile[k];
        end
      end
    end
  end

  // Tile compare and read result
  always_comb begin
    cmp_acc = '0;
    for (int k = 0; k < PLANES; k++) begin
      if (!mode[k]) begin
        cmp_acc = cmp_acc | (rdata[8*k +: 8] ^ tile[k]);
      end
    end
    raw_byte = rdata[{plane_q, 3'b000} +: 8];
    if (!hit_q) begin
      result = FILL_BYTE;
    end else if (!mode[MODE_ON_BIT] || mode[MODE_RMW_BIT]) begin
      result = raw_byte;
    end else begin
      result = ~cmp_acc;
    end
  end

  // Select the write port source: clear sweep or finished write
  always_comb begin
    ram_we    = cmd.clr_en || (cmd.finish_wr && hit_q);
    ram_waddr = cmd.clr_en ? clr_addr : idx_q;
    ram_wdata = cmd.clr_en ? '0 : merged;
  end

  vtre_plane_ram #(
    .DEPTH(PLANE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.accept),
    .raddr(idx_in),
    .rdata(rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= result;
    end
  end

endmodule

// ===== hw/rtl/vtre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtre_ctrl
// Controller: clear sweep after reset, accept, and the finish state of a
// memory transaction.
// ----------------------------------------------------------------------------
module vtre_ctrl import vtre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  ctrl_status_t st,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && st.in_is_mem) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st.pend_read) begin
          if (!st.out_busy) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.finish_wr = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Advance the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_mem_to_finish: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && st.in_is_mem) |=> (state == S_FINISH))
    else $error("memory transaction did not reach finish cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_busy)
    else $error("result loaded over a stalled result");

  a_one_finish_action: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish_wr && cmd.out_load))
    else $error("write and result load in one cycle");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> !cmd.accept)
    else $error("transaction accepted during clear sweep");
`endif

endmodule

// ===== verif/planar_vram_tile_raster_engine_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_vram_tile_raster_engine_core_test
// Self-checking bench for the tile raster engine core. A directed table hits
// the windows' edges, planar access, mode and tile loads, tile writes,
// masked writes, raw and compare reads. Random traffic follows: mode and tile
// programming runs, then window reads and writes over a few hot offsets, with
// stray ports, unused commands and out-of-window accesses mixed in. A shadow
// image of the four planes predicts every read, and the results are compared
// in order. Both channels idle and stall in several phases.
// ----------------------------------------------------------------------------
module planar_vram_tile_raster_engine_core_test import vtre_pkg::*; ();

  localparam int VRAM_DEPTH     = PLANE_BYTES_DEF;
  localparam int DIR_ROWS       = 25;
  localparam int RAND_PER_PHASE = 332;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 600000;

  // One bus transaction; want holds a typed-in read result when typed is set
  typedef struct packed {
    cmd_e        cmd;
    logic [19:0] addr;
    logic [7:0]  data;
    logic        typed;
    logic [7:0]  want;
  } bus_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = 2'd0;
  logic [19:0] bus_address = 20'd0;
  logic [7:0]  write_data = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;

  // Shadow state of the engine
  logic [31:0] vram_img [VRAM_DEPTH];
  logic [7:0]  eng_mode;
  logic [7:0]  tile_val [PLANES];
  logic [1:0]  tile_ptr;

  logic [7:0]  rd_expect_q [$];
  bus_row_t    dir_rows [DIR_ROWS];
  logic [14:0] hot_ofs [8];
  int          mismatch_cnt = 0;
  int          cyc = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  planar_vram_tile_raster_engine_core #(
    .PLANE_BYTES(VRAM_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .bus_address(bus_address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("planar_vram_tile_raster_engine_core regression: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("[%0t] %s: read_data %h, expected %h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Apply one bus transaction to the shadow state; return the read byte
  task automatic model_txn(input bus_row_t r, output bit has_rd, output logic [7:0] rd);
    int         pl;
    int         ofs;
    logic [7:0] acc;
    logic [7:0] old;
    has_rd = 1'b0;
    rd     = FILL_BYTE;
    case (r.addr[19:15])
      5'h15:   pl = 0;
      5'h16:   pl = 1;
      5'h17:   pl = 2;
      5'h1c:   pl = 3;
      default: pl = -1;
    endcase
    ofs = int'(r.addr[14:0]) % VRAM_DEPTH;
    case (r.cmd)
      CMD_IO: begin
        if (r.addr[15:0] == PORT_MODE) begin
          eng_mode = r.data;
          tile_ptr = 2'd0;
        end else if (r.addr[15:0] == PORT_TILE) begin
          tile_val[tile_ptr] = r.data;
          tile_ptr = tile_ptr + 2'd1;
        end
      end
      CMD_WRITE: begin
        if (pl >= 0) begin
          if (!eng_mode[MODE_ON_BIT]) begin
            vram_img[ofs][8*pl +: 8] = r.data;
          end else begin
            for (int k = 0; k < PLANES; k++) begin
              if (!eng_mode[k]) begin
                old = vram_img[ofs][8*k +: 8];
                vram_img[ofs][8*k +: 8] = eng_mode[MODE_RMW_BIT] ?
                    ((old & ~r.data) | (tile_val[k] & r.data)) : tile_val[k];
              end
            end
          end
        end
      end
      CMD_READ: begin
        has_rd = 1'b1;
        if (pl >= 0) begin
          if (!eng_mode[MODE_ON_BIT] || eng_mode[MODE_RMW_BIT]) begin
            rd = vram_img[ofs][8*pl +: 8];
          end else begin
            // tile compare over the enabled planes
            acc = 8'h00;
            for (int k = 0; k < PLANES; k++) begin
              if (!eng_mode[k]) acc = acc | (vram_img[ofs][8*k +: 8] ^ tile_val[k]);
            end
            rd = ~acc;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one transaction from a falling edge; return at the falling edge after accept
  task automatic send_txn(input bus_row_t r);
    bit         has_rd;
    logic [7:0] rd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= r.cmd;
    bus_address <= r.addr;
    write_data  <= r.data;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    model_txn(r, has_rd, rd);
    if (has_rd) rd_expect_q.push_back(r.typed ? r.want : rd);
    @(negedge clk);
  endtask

  // Issue one random run of traffic and count every transaction sent
  task automatic random_burst(inout int n_items);
    bus_row_t   r;
    int         pick;
    int         n_tiles;
    logic [7:0] mode;
    r      = '0;
    r.data = 8'($urandom);
    pick   = $urandom_range(99);
    if (pick < 12) begin
      // program the mode, then load tiles; some loads stop short or run over
      mode = 8'($urandom);
      mode[MODE_ON_BIT] = ($urandom_range(3) != 0);
      if ($urandom_range(7) == 0) mode[PLANES-1:0] = '1;
      r.cmd  = CMD_IO;
      r.addr = 20'($urandom);
      if ($urandom_range(3) != 0) r.addr[19:16] = 4'h0;
      r.addr[15:0] = PORT_MODE;
      r.data = mode;
      send_txn(r);
      n_tiles = ($urandom_range(4) == 0) ? $urandom_range(5) : PLANES;
      r.addr[15:0] = PORT_TILE;
      for (int t = 0; t < n_tiles; t++) begin
        r.data = 8'($urandom);
        send_txn(r);
      end
      n_items += 1 + n_tiles;
    end else if (pick < 82) begin
      // window access, mostly on a few hot offsets so reads see earlier writes
      r.cmd = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
      case ($urandom_range(3))
        0:       r.addr = WIN0_BASE;
        1:       r.addr = WIN1_BASE;
        2:       r.addr = WIN2_BASE;
        default: r.addr = WIN3_BASE;
      endcase
      r.addr[14:0] = ($urandom_range(3) == 0) ? 15'($urandom) : hot_ofs[$urandom_range(7)];
      send_txn(r);
      n_items++;
    end else if (pick < 90) begin
      r.cmd  = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
      r.addr = 20'($urandom);
      send_txn(r);
      n_items++;
    end else if (pick < 96) begin
      r.cmd  = CMD_IO;
      r.addr = 20'($urandom);
      send_txn(r);
      n_items++;
    end else begin
      r.cmd  = CMD_NONE;
      r.addr = 20'($urandom);
      send_txn(r);
      n_items++;
    end
  endtask

  // Drive the result stall: random per phase, or a long hold on request
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted result against the oldest pending read
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (rd_expect_q.size() == 0) begin
        flag_mismatch("result with no read pending", read_data, 8'hxx);
      end else if (read_data !== rd_expect_q[0]) begin
        flag_mismatch("read result mismatch", read_data, rd_expect_q[0]);
        void'(rd_expect_q.pop_front());
      end else begin
        void'(rd_expect_q.pop_front());
      end
    end
  end

  initial begin
    int n_items;
    bit held;
    bit paused;
    n_items = 0;
    held    = 1'b0;
    paused  = 1'b0;

    dir_rows = '{
      '{CMD_READ,  20'ha8000, 8'h00, 1'b1, 8'h00},   // cleared after reset
      '{CMD_READ,  20'he7fff, 8'h00, 1'b1, 8'h00},
      '{CMD_READ,  20'h00000, 8'h00, 1'b1, 8'hff},   // outside every window
      '{CMD_READ,  20'hfffff, 8'hff, 1'b1, 8'hff},
      '{CMD_READ,  20'hc0000, 8'h00, 1'b1, 8'hff},
      '{CMD_WRITE, 20'ha8000, 8'hff, 1'b0, 8'h00},   // planar writes, engine off
      '{CMD_WRITE, 20'hb0000, 8'h5a, 1'b0, 8'h00},
      '{CMD_READ,  20'ha8000, 8'h00, 1'b0, 8'h00},
      '{CMD_READ,  20'hb0000, 8'h00, 1'b0, 8'h00},
      '{CMD_WRITE, 20'h12345, 8'h77, 1'b0, 8'h00},   // write outside windows
      '{CMD_NONE,  20'ha8000, 8'h00, 1'b0, 8'h00},
      '{CMD_IO,    20'h0007c, 8'h80, 1'b0, 8'h00},   // engine on, compare
      '{CMD_IO,    20'hf007e, 8'hff, 1'b0, 8'h00},
      '{CMD_IO,    20'h0007e, 8'h5a, 1'b0, 8'h00},
      '{CMD_IO,    20'h0007e, 8'h00, 1'b0, 8'h00},
      '{CMD_IO,    20'h0007e, 8'h00, 1'b0, 8'h00},
      '{CMD_READ,  20'hb8000, 8'h00, 1'b0, 8'h00},
      '{CMD_IO,    20'h0007d, 8'h12, 1'b0, 8'h00},   // unused port
      '{CMD_IO,    20'h0007c, 8'hc4, 1'b0, 8'h00},   // masked write, plane 2 off
      '{CMD_WRITE, 20'he0001, 8'h0f, 1'b0, 8'h00},
      '{CMD_READ,  20'ha8001, 8'h00, 1'b0, 8'h00},
      '{CMD_IO,    20'h0007c, 8'h81, 1'b0, 8'h00},   // whole-tile write
      '{CMD_WRITE, 20'hb8003, 8'h00, 1'b0, 8'h00},
      '{CMD_IO,    20'h8007c, 8'h8f, 1'b0, 8'h00},   // every plane disabled
      '{CMD_READ,  20'he0000, 8'h00, 1'b1, 8'hff}
    };

    // Clear the shadow state the same way reset clears the planes
    for (int i = 0; i < VRAM_DEPTH; i++) vram_img[i] = 32'h0;
    for (int i = 0; i < PLANES; i++) tile_val[i] = 8'h00;
    eng_mode = 8'h00;
    tile_ptr = 2'd0;
    hot_ofs[0] = 15'h0000;
    hot_ofs[1] = 15'h7fff;
    for (int i = 2; i < 8; i++) hot_ofs[i] = 15'($urandom);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) send_txn(dir_rows[i]);
    n_items = DIR_ROWS;

    // Random traffic under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 72;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 72;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct <= 25;
        end
      endcase
      while (n_items < DIR_ROWS + (ph + 1) * RAND_PER_PHASE) begin
        // hold off results while the sender keeps pushing
        if (ph == 0 && !held && n_items > DIR_ROWS + 120) begin
          hold_asks <= hold_asks + 1;
          held = 1'b1;
        end
        // pause the sender until every pending read has come back
        if (ph == 3 && !paused && n_items > DIR_ROWS + 3 * RAND_PER_PHASE + 150) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (rd_expect_q.size() != 0) @(negedge clk);
          paused = 1'b1;
        end
        random_burst(n_items);
      end
    end

    // Drain the outstanding reads
    in_valid <= 1'b0;
    while (rd_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("planar_vram_tile_raster_engine_core regression: pass");
    end else begin
      $display("planar_vram_tile_raster_engine_core regression: fail");
    end
    $finish;
  end

endmodule
